// File: hdl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg: shared types, constants and helpers for the YUV 4:2:0 to RGB888 block
// Holds the BT.601 fixed point coefficients, datapath widths, the chroma term
// bundle passed to the lanes and the channel clamp.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int SAMPLE_W = 8;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = 28;
    localparam int FRAC_W   = 16;
    localparam int LANES    = 4;

    localparam int IN_W  = 6 * SAMPLE_W;
    localparam int OUT_W = 3 * LANES * SAMPLE_W;

    localparam logic signed [DIFF_W-1:0] LUMA_OFS   = 9'sd16;
    localparam logic signed [DIFF_W-1:0] CHROMA_OFS = 9'sd128;

    localparam logic signed [PROD_W-1:0] COEF_Y  = 28'sd76309;
    localparam logic signed [PROD_W-1:0] COEF_RV = 28'sd104597;
    localparam logic signed [PROD_W-1:0] COEF_GU = 28'sd25675;
    localparam logic signed [PROD_W-1:0] COEF_GV = 28'sd53279;
    localparam logic signed [PROD_W-1:0] COEF_BU = 28'sd132201;

    typedef logic signed [PROD_W-1:0] prod_t;

    // Chroma contributions shared by all four pixels of a block.
    typedef struct packed {
        prod_t red;
        prod_t green_u;
        prod_t green_v;
        prod_t blue;
    } chroma_terms_t;

    // Floor shift by FRAC_W and clamp to 0..255.
    function automatic logic [SAMPLE_W-1:0] clamp_channel(input prod_t sum);
        logic [SAMPLE_W-1:0] result;
        begin
            if (sum[PROD_W-1])
            begin
                result = '0;
            end
            else if (|sum[PROD_W-2:FRAC_W+SAMPLE_W])
            begin
                result = '1;
            end
            else
            begin
                result = sum[FRAC_W+SAMPLE_W-1:FRAC_W];
            end
            return result;
        end
    endfunction

endpackage

// File: hdl/y2r_chroma.sv
// ----------------------------------------------------------------------------
// y2r_chroma: shared chroma product unit
// Picks U and V from the incoming pair, removes the offset and registers the
// four chroma products used by every pixel lane.
// ----------------------------------------------------------------------------
module y2r_chroma
(
    input  logic                                clk,
    input  logic                                load,
    input  logic                                swap_chroma,
    input  logic [y2r_pkg::SAMPLE_W-1:0]        chroma_first,
    input  logic [y2r_pkg::SAMPLE_W-1:0]        chroma_second,
    output y2r_pkg::chroma_terms_t              terms
);

    logic signed [y2r_pkg::DIFF_W-1:0] u_diff;
    logic signed [y2r_pkg::DIFF_W-1:0] v_diff;
    y2r_pkg::chroma_terms_t            terms_reg;
    y2r_pkg::chroma_terms_t            terms_next;

    always_comb
    begin
        if (swap_chroma)
        begin
            u_diff = $signed({1'b0, chroma_second}) - y2r_pkg::CHROMA_OFS;
            v_diff = $signed({1'b0, chroma_first}) - y2r_pkg::CHROMA_OFS;
        end
        else
        begin
            u_diff = $signed({1'b0, chroma_first}) - y2r_pkg::CHROMA_OFS;
            v_diff = $signed({1'b0, chroma_second}) - y2r_pkg::CHROMA_OFS;
        end
        terms_next.red     = y2r_pkg::PROD_W'(v_diff) * y2r_pkg::COEF_RV;
        terms_next.green_u = y2r_pkg::PROD_W'(u_diff) * y2r_pkg::COEF_GU;
        terms_next.green_v = y2r_pkg::PROD_W'(v_diff) * y2r_pkg::COEF_GV;
        terms_next.blue    = y2r_pkg::PROD_W'(u_diff) * y2r_pkg::COEF_BU;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// File: hdl/y2r_lane.sv
// ----------------------------------------------------------------------------
// y2r_lane: one pixel lane
// Registers the scaled luma of one pixel, then adds the shared chroma terms
// and clamps each of the three channels.
// ----------------------------------------------------------------------------
module y2r_lane
(
    input  logic                                clk,
    input  logic                                load,
    input  logic [y2r_pkg::SAMPLE_W-1:0]        luma,
    input  y2r_pkg::chroma_terms_t              terms,
    output logic [y2r_pkg::SAMPLE_W-1:0]        red,
    output logic [y2r_pkg::SAMPLE_W-1:0]        green,
    output logic [y2r_pkg::SAMPLE_W-1:0]        blue
);

    logic signed [y2r_pkg::DIFF_W-1:0] y_diff;
    y2r_pkg::prod_t                    luma_reg;
    y2r_pkg::prod_t                    luma_next;

    assign y_diff    = $signed({1'b0, luma}) - y2r_pkg::LUMA_OFS;
    assign luma_next = y2r_pkg::PROD_W'(y_diff) * y2r_pkg::COEF_Y;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            luma_reg <= luma_next;
        end
    end

    assign red   = y2r_pkg::clamp_channel(luma_reg + terms.red);
    assign green = y2r_pkg::clamp_channel(luma_reg - terms.green_u - terms.green_v);
    assign blue  = y2r_pkg::clamp_channel(luma_reg + terms.blue);

endmodule

// File: hdl/yuv420_block_to_rgb888.sv
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb888: 2x2 YUV 4:2:0 block to four RGB888 pixels
// Top level with input handshake, product stage, four pixel lanes and the
// merging output register.
// ----------------------------------------------------------------------------
// The block converts one 2x2 block of a 4:2:0 frame per item: four luma
// samples and one shared chroma pair come in, four RGB888 pixels go out, using
// BT.601 studio-range coefficients in 16.16 fixed point with floor rounding
// and clamping to 0..255. It accepts one item every clock cycle unless both
// stages are full and the output stalls. The first stage registers the luma
// and chroma products (one multiplier per product), the second stage adds,
// clamps and merges the four lanes into the output register. Each stage holds
// its item only while the stage after it is full and stalled, so the input
// keeps taking items while a finished result waits, until both stages fill.
// The swap_chroma register (written through cfg_we / cfg_wdata, reset to 0)
// selects YVU chroma order when set; it should be changed only while idle.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb888
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic                            cfg_wdata,      // swap_chroma

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0 up: luma_top_left, luma_top_right, luma_bottom_left,
    // luma_bottom_right, chroma_first, chroma_second (8 bits each).
    input  logic [y2r_pkg::IN_W-1:0]        s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0 up, 8 bits each: red, green, blue of top_left, then of
    // top_right, bottom_left and bottom_right.
    output logic [y2r_pkg::OUT_W-1:0]       m_tdata
);

    localparam int SW = y2r_pkg::SAMPLE_W;

    logic                           swap_chroma_reg;
    logic                           prod_valid_reg;
    logic                           out_valid_reg;
    logic [y2r_pkg::OUT_W-1:0]      out_data_reg;
    logic [y2r_pkg::OUT_W-1:0]      out_data_next;
    logic                           out_load;
    logic                           prod_load;
    y2r_pkg::chroma_terms_t         terms;

    // Each stage moves on when the stage after it is empty or moving.
    assign out_load  = !out_valid_reg || m_tready;
    assign prod_load = !prod_valid_reg || out_load;
    assign s_tready  = prod_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_chroma_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            swap_chroma_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_load)
            begin
                prod_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // Shared chroma unit: products are computed once per block.
    y2r_chroma u_chroma
    (
        .clk           (clk),
        .load          (prod_load),
        .swap_chroma   (swap_chroma_reg),
        .chroma_first  (s_tdata[4*SW +: SW]),
        .chroma_second (s_tdata[5*SW +: SW]),
        .terms         (terms)
    );

    // One lane per pixel; each lane drops its RGB triple into its own slice
    // of the merged result word.
    for (genvar lane = 0; lane < y2r_pkg::LANES; lane++)
    begin : g_lane
        y2r_lane u_lane
        (
            .clk   (clk),
            .load  (prod_load),
            .luma  (s_tdata[lane*SW +: SW]),
            .terms (terms),
            .red   (out_data_next[(3*lane+0)*SW +: SW]),
            .green (out_data_next[(3*lane+1)*SW +: SW]),
            .blue  (out_data_next[(3*lane+2)*SW +: SW])
        );
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
